### rtl/phtc_pkg.sv
// Shared types and constants of the pressure, humidity and temperature compensation block.
package phtc_pkg;

  // Stage counts of each pipeline section
  localparam int LatTemp    = 3;
  localparam int LatPre     = 5;
  localparam int DivStages  = 64;
  localparam int LatPost    = 5;
  localparam int LatHum     = 7;
  localparam int PipeDepth  = 1 + LatTemp + LatPre + DivStages + LatPost;
  localparam int TcDelay    = LatPre + DivStages + LatPost;
  localparam int HumDelay   = TcDelay - LatHum;

  // Output limits
  localparam logic signed [14:0] TempMinCenti = -15'sd4000;
  localparam logic signed [14:0] TempMaxCenti = 15'sd8500;
  localparam logic signed [31:0] HumCap       = 32'sd419430400;

  // Decoded trim coefficients
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } trim_t;

endpackage

### rtl/phtc_temp.sv
// Temperature compensation pipeline producing fine temperature and centi-degree result.
module phtc_temp
  import phtc_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  trim_t               trim_i,
  input  logic [19:0]         raw_t_i,
  input  logic [19:0]         raw_p_i,
  input  logic [15:0]         raw_h_i,
  output logic signed [21:0]  tfine_o,
  output logic signed [14:0]  tc_o,
  output logic [19:0]         raw_p_o,
  output logic [15:0]         raw_h_o
);

  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic signed [33:0] d1t2_full;
  logic signed [33:0] d2sq_full;
  logic [31:0]        d1t2_q, d2sq_q;
  logic signed [19:0] sq_s;
  logic signed [35:0] st3_full;
  logic signed [20:0] v1_q;
  logic signed [17:0] v2_q;
  logic signed [21:0] tfine;
  logic signed [24:0] t5;
  logic signed [16:0] tcs;
  logic signed [14:0] tc_d;
  logic [19:0]        rp1_q, rp2_q;
  logic [15:0]        rh1_q, rh2_q;

  // Stage 1: offsets against T1 and first products
  assign d1 = $signed({1'b0, raw_t_i[19:3]}) - $signed({1'b0, trim_i.t1, 1'b0});
  assign d2 = $signed({1'b0, raw_t_i[19:4]}) - $signed({1'b0, trim_i.t1});
  assign d1t2_full = d1 * $signed(trim_i.t2);
  assign d2sq_full = d2 * d2;

  // Stage 2: scale square by T3
  assign sq_s     = $signed(d2sq_q[31:12]);
  assign st3_full = sq_s * $signed(trim_i.t3);

  // Stage 3: fine temperature and saturated centi-degrees
  assign tfine = v1_q + v2_q;
  assign t5    = tfine * 25'sd5 + 25'sd128;
  assign tcs   = $signed(t5[24:8]);

  always_comb begin
    if (tcs < TempMinCenti) begin
      tc_d = TempMinCenti;
    end else if (tcs > TempMaxCenti) begin
      tc_d = TempMaxCenti;
    end else begin
      tc_d = tcs[14:0];
    end
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1t2_q  <= d1t2_full[31:0];
      d2sq_q  <= d2sq_full[31:0];
      rp1_q   <= raw_p_i;
      rh1_q   <= raw_h_i;
      v1_q    <= $signed(d1t2_q[31:11]);
      v2_q    <= $signed(st3_full[31:14]);
      rp2_q   <= rp1_q;
      rh2_q   <= rh1_q;
      tfine_o <= tfine;
      tc_o    <= tc_d;
      raw_p_o <= rp2_q;
      raw_h_o <= rh2_q;
    end
  end

endmodule

### rtl/phtc_press_pre.sv
// Pressure front end: offset polynomial, divisor and dividend in sign-magnitude form.
module phtc_press_pre
  import phtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  trim_t              trim_i,
  input  logic signed [21:0] tfine_i,
  input  logic [19:0]        raw_p_i,
  output logic [63:0]        num_mag_o,
  output logic [30:0]        den_mag_o,
  output logic               neg_o,
  output logic               inv_o
);

  logic signed [22:0] a;
  logic signed [45:0] aa_q;
  logic signed [38:0] ap5_q, ap2_q, ap5_2q, ap2_2q;
  logic [20:0]        p_q, p2_q, p3_q;
  logic signed [61:0] aap6_q, aap3_q;
  logic signed [61:0] aap3s;
  logic signed [63:0] b_d, x64;
  logic [63:0]        b_q;
  logic signed [51:0] x_q;
  logic signed [68:0] y_full;
  logic [63:0]        t_diff;
  logic [63:0]        num_q;
  logic signed [30:0] dvs_q;

  // Stage 1: centered fine temperature and its first products
  assign a = 23'(tfine_i) - 23'sd128000;

  // Stage 3: sums of the offset and sensitivity terms
  assign aap3s = aap3_q >>> 8;
  assign b_d = 64'(aap6_q) + (64'(ap5_2q) <<< 17) + (64'($signed(trim_i.p4)) <<< 35);
  assign x64 = 64'(aap3s) + (64'(ap2_2q) <<< 12) + 64'sd140737488355328;

  // Stage 4: divisor and scaled dividend
  assign y_full = x_q * $signed({1'b0, trim_i.p1});
  assign t_diff = {12'b0, p3_q, 31'b0} - b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aa_q      <= a * a;
      ap5_q     <= a * $signed(trim_i.p5);
      ap2_q     <= a * $signed(trim_i.p2);
      p_q       <= 21'd1048576 - {1'b0, raw_p_i};
      aap6_q    <= aa_q * $signed(trim_i.p6);
      aap3_q    <= aa_q * $signed(trim_i.p3);
      ap5_2q    <= ap5_q;
      ap2_2q    <= ap2_q;
      p2_q      <= p_q;
      b_q       <= b_d;
      x_q       <= x64[51:0];
      p3_q      <= p2_q;
      dvs_q     <= $signed(y_full[63:33]);
      num_q     <= t_diff * 64'd3125;
      // Stage 5: split into sign and magnitudes
      neg_o     <= num_q[63] ^ dvs_q[30];
      num_mag_o <= num_q[63] ? (64'd0 - num_q) : num_q;
      den_mag_o <= dvs_q[30] ? (31'd0 - dvs_q) : dvs_q;
      inv_o     <= (dvs_q == '0);
    end
  end

endmodule

### rtl/phtc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module phtc_div
  import phtc_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [30:0] den_i,
  input  logic        neg_i,
  input  logic        inv_i,
  output logic [63:0] quo_o,
  output logic        neg_o,
  output logic        inv_o
);

  logic [30:0] rem_q [DivStages];
  logic [63:0] sh_q  [DivStages];
  logic [30:0] den_q [DivStages];
  logic        neg_q [DivStages];
  logic        inv_q [DivStages];

  logic [30:0] rem_in [DivStages];
  logic [63:0] sh_in  [DivStages];
  logic [30:0] den_in [DivStages];
  logic [31:0] trial  [DivStages];
  logic [31:0] diff   [DivStages];
  logic        fit    [DivStages];

  for (genvar g = 0; g < DivStages; g++) begin : g_stage
    // Select this stage's operands
    if (g == 0) begin : g_first
      assign rem_in[g] = '0;
      assign sh_in[g]  = num_i;
      assign den_in[g] = den_i;
    end else begin : g_next
      assign rem_in[g] = rem_q[g-1];
      assign sh_in[g]  = sh_q[g-1];
      assign den_in[g] = den_q[g-1];
    end

    // Trial subtract of the divisor
    assign trial[g] = {rem_in[g], sh_in[g][63]};
    assign diff[g]  = trial[g] - {1'b0, den_in[g]};
    assign fit[g]   = (trial[g] >= {1'b0, den_in[g]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= fit[g] ? diff[g][30:0] : trial[g][30:0];
        sh_q[g]  <= {sh_in[g][62:0], fit[g]};
        den_q[g] <= den_in[g];
      end
    end
  end

  // Carry flags alongside
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= neg_i;
      inv_q[0] <= inv_i;
      for (int i = 1; i < DivStages; i++) begin
        neg_q[i] <= neg_q[i-1];
        inv_q[i] <= inv_q[i-1];
      end
    end
  end

  assign quo_o = sh_q[DivStages-1];
  assign neg_o = neg_q[DivStages-1];
  assign inv_o = inv_q[DivStages-1];

endmodule

### rtl/phtc_press_post.sv
// Pressure back end: quotient correction terms and Q24.8 saturation.
module phtc_press_post
  import phtc_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  trim_t       trim_i,
  input  logic [63:0] quo_i,
  input  logic        neg_i,
  input  logic        inv_i,
  output logic [31:0] pres_o,
  output logic        inv_o
);

  logic signed [63:0] q;
  logic signed [50:0] q13;
  logic signed [66:0] m9_full;
  logic signed [79:0] m8_full;
  logic [63:0]        q1_q, q2_q, q3_q;
  logic [63:0]        m9_q, m8_q;
  logic               inv1_q, inv2_q, inv3_q, inv4_q;
  logic [63:0]        q13x;
  logic signed [63:0] e2_d, e2_q, e2_2q;
  logic [63:0]        pp_ll_q;
  logic [31:0]        pp_x1_q, pp_x2_q;
  logic [63:0]        e1p_q;
  logic signed [63:0] e1, s_d, s_q;
  logic signed [63:0] sh8, p7x, r;
  logic [31:0]        pres_d;

  // Stage 1: restore sign, first products
  assign q       = neg_i ? $signed(64'd0 - quo_i) : $signed(quo_i);
  assign q13     = $signed(q[63:13]);
  assign m9_full = $signed(trim_i.p9) * q13;
  assign m8_full = $signed(trim_i.p8) * q;

  // Stage 2: partial products of the square term
  assign q13x = {{13{q1_q[63]}}, q1_q[63:13]};
  assign e2_d = $signed(m8_q) >>> 19;

  // Stage 4: add correction terms
  assign e1  = $signed(e1p_q) >>> 25;
  assign s_d = $signed(q3_q) + e1 + e2_2q;

  // Stage 5: offset by P7 and saturate, forcing zero when the result is invalid
  assign sh8 = s_q >>> 8;
  assign p7x = 64'($signed(trim_i.p7)) <<< 4;
  assign r   = sh8 + p7x;

  always_comb begin
    if (inv4_q || r < 64'sd0) begin
      pres_d = '0;
    end else if (r > 64'sd4294967295) begin
      pres_d = '1;
    end else begin
      pres_d = r[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_q    <= q;
      m9_q    <= m9_full[63:0];
      m8_q    <= m8_full[63:0];
      inv1_q  <= inv_i;
      q2_q    <= q1_q;
      e2_q    <= e2_d;
      pp_ll_q <= m9_q[31:0] * q13x[31:0];
      pp_x1_q <= m9_q[31:0] * q13x[63:32];
      pp_x2_q <= m9_q[63:32] * q13x[31:0];
      inv2_q  <= inv1_q;
      q3_q    <= q2_q;
      e2_2q   <= e2_q;
      e1p_q   <= pp_ll_q + {pp_x1_q + pp_x2_q, 32'b0};
      inv3_q  <= inv2_q;
      s_q     <= s_d;
      inv4_q  <= inv3_q;
      pres_o  <= pres_d;
      inv_o   <= inv4_q;
    end
  end

endmodule

### rtl/phtc_hum.sv
// Humidity compensation pipeline in 32-bit wrapping arithmetic.
module phtc_hum
  import phtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  trim_t              trim_i,
  input  logic signed [21:0] tfine_i,
  input  logic [15:0]        raw_h_i,
  output logic [16:0]        hum_o
);

  logic signed [31:0] v, h5x, h6x, h3x, h2x, h1x;
  logic [31:0]        base_q, diff;
  logic signed [31:0] h5v_q, vh6_q, vh3_q;
  logic signed [16:0] ha_q, ha2_q;
  logic signed [31:0] hb, hc, prod_q, hd, p2_q, he, hax;
  logic signed [31:0] vv_q, vv2_q, vv3_q, wx, sq_q, sqs, t_q, ts, f;
  logic signed [16:0] w;
  logic [31:0]        clamped;

  assign h5x = 32'($signed(trim_i.h5));
  assign h6x = 32'($signed(trim_i.h6));
  assign h2x = 32'($signed(trim_i.h2));
  assign h3x = $signed({24'b0, trim_i.h3});
  assign h1x = $signed({24'b0, trim_i.h1});

  // Stage 1: temperature offset products
  assign v = 32'(tfine_i) - 32'sd76800;

  // Stage 2: humidity base and temperature gain
  assign diff = base_q - h5v_q;
  assign hb   = vh6_q >>> 10;
  assign hc   = (vh3_q >>> 11) + 32'sd32768;

  // Stage 3: scale by H2
  assign hd = (prod_q >>> 10) + 32'sd2097152;

  // Stage 4: combine base and gain
  assign he  = (p2_q + 32'sd8192) >>> 14;
  assign hax = 32'(ha2_q);

  // Stage 5: square term
  assign w  = $signed(vv_q[31:15]);
  assign wx = 32'(w);

  // Stage 6: weight by H1
  assign sqs = sq_q >>> 7;

  // Stage 7: subtract and clamp
  assign ts = t_q >>> 4;
  assign f  = vv3_q - ts;

  always_comb begin
    if (f < 32'sd0) begin
      clamped = '0;
    end else if (f > HumCap) begin
      clamped = HumCap;
    end else begin
      clamped = f;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q <= {2'b0, raw_h_i, 14'b0} - {trim_i.h4, 20'b0} + 32'd16384;
      h5v_q  <= h5x * v;
      vh6_q  <= v * h6x;
      vh3_q  <= v * h3x;
      ha_q   <= $signed(diff[31:15]);
      prod_q <= hb * hc;
      ha2_q  <= ha_q;
      p2_q   <= hd * h2x;
      vv_q   <= hax * he;
      vv2_q  <= vv_q;
      sq_q   <= wx * wx;
      vv3_q  <= vv2_q;
      t_q    <= sqs * h1x;
      hum_o  <= clamped[28:12];
    end
  end

endmodule

### rtl/pressure_humidity_temp_compensation.sv
// Top level of the pressure, humidity and temperature compensation pipeline.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_ready_o | raw_temperature, raw_pressure, raw_humidity
//  out     | output    | out_valid_o/out_ready_i | temperature_centi, pressure_q24_8,
//          |           |                         | pressure_invalid, humidity_q22_10
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction is accepted per cycle unless the output holds an untaken result.
// The 64-stage divider yields one quotient bit per stage.
// Reset clears trim registers and valid bits; no clearing pass is needed.
// When the output holds an untaken result, the whole pipeline freezes and nothing is lost.
module pressure_humidity_temp_compensation
  import phtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [19:0]        raw_temperature_i,
  input  logic [19:0]        raw_pressure_i,
  input  logic [15:0]        raw_humidity_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] temperature_centi_o,
  output logic [31:0]        pressure_q24_8_o,
  output logic               pressure_invalid_o,
  output logic [16:0]        humidity_q22_10_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i
);

  typedef enum logic [2:0] {
    CfgTempTrim  = 3'd0,
    CfgPressA    = 3'd1,
    CfgPressB    = 3'd2,
    CfgPressC    = 3'd3,
    CfgHumA      = 3'd4,
    CfgHumB      = 3'd5
  } cfg_idx_e;

  logic [47:0] temp_trim_q, press_a_q, press_b_q, press_c_q;
  logic [31:0] hum_a_q, hum_b_q;
  trim_t       trim;

  logic        en;
  logic        vld_q [PipeDepth];
  logic [19:0] rt_q, rp_q;
  logic [15:0] rh_q;

  logic signed [21:0] tfine;
  logic signed [14:0] tc;
  logic [19:0]        rp_t;
  logic [15:0]        rh_t;
  logic [63:0]        num_mag, quo;
  logic [30:0]        den_mag;
  logic               neg_a, inv_a, neg_b, inv_b;
  logic [16:0]        hum;
  logic signed [14:0] tc_dly_q  [TcDelay];
  logic [16:0]        hum_dly_q [HumDelay];

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q <= '0;
      press_a_q   <= '0;
      press_b_q   <= '0;
      press_c_q   <= '0;
      hum_a_q     <= '0;
      hum_b_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTempTrim: temp_trim_q <= cfg_data_i;
        CfgPressA:   press_a_q   <= cfg_data_i;
        CfgPressB:   press_b_q   <= cfg_data_i;
        CfgPressC:   press_c_q   <= cfg_data_i;
        CfgHumA:     hum_a_q     <= cfg_data_i[31:0];
        CfgHumB:     hum_b_q     <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Unpack trim coefficients
  always_comb begin
    trim.t1 = temp_trim_q[15:0];
    trim.t2 = temp_trim_q[31:16];
    trim.t3 = temp_trim_q[47:32];
    trim.p1 = press_a_q[15:0];
    trim.p2 = press_a_q[31:16];
    trim.p3 = press_a_q[47:32];
    trim.p4 = press_b_q[15:0];
    trim.p5 = press_b_q[31:16];
    trim.p6 = press_b_q[47:32];
    trim.p7 = press_c_q[15:0];
    trim.p8 = press_c_q[31:16];
    trim.p9 = press_c_q[47:32];
    trim.h1 = hum_a_q[7:0];
    trim.h2 = hum_a_q[23:8];
    trim.h3 = hum_a_q[31:24];
    trim.h4 = hum_b_q[11:0];
    trim.h5 = hum_b_q[23:12];
    trim.h6 = hum_b_q[31:24];
  end

  // Advance unless the output holds an untaken result
  assign en         = !vld_q[PipeDepth-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PipeDepth; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < PipeDepth; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Capture input transaction
  always_ff @(posedge clk_i) begin
    if (en) begin
      rt_q <= raw_temperature_i;
      rp_q <= raw_pressure_i;
      rh_q <= raw_humidity_i;
    end
  end

  phtc_temp u_temp (
    .clk_i   (clk_i),
    .en_i    (en),
    .trim_i  (trim),
    .raw_t_i (rt_q),
    .raw_p_i (rp_q),
    .raw_h_i (rh_q),
    .tfine_o (tfine),
    .tc_o    (tc),
    .raw_p_o (rp_t),
    .raw_h_o (rh_t)
  );

  phtc_press_pre u_pre (
    .clk_i     (clk_i),
    .en_i      (en),
    .trim_i    (trim),
    .tfine_i   (tfine),
    .raw_p_i   (rp_t),
    .num_mag_o (num_mag),
    .den_mag_o (den_mag),
    .neg_o     (neg_a),
    .inv_o     (inv_a)
  );

  phtc_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_mag),
    .den_i (den_mag),
    .neg_i (neg_a),
    .inv_i (inv_a),
    .quo_o (quo),
    .neg_o (neg_b),
    .inv_o (inv_b)
  );

  phtc_press_post u_post (
    .clk_i  (clk_i),
    .en_i   (en),
    .trim_i (trim),
    .quo_i  (quo),
    .neg_i  (neg_b),
    .inv_i  (inv_b),
    .pres_o (pressure_q24_8_o),
    .inv_o  (pressure_invalid_o)
  );

  phtc_hum u_hum (
    .clk_i   (clk_i),
    .en_i    (en),
    .trim_i  (trim),
    .tfine_i (tfine),
    .raw_h_i (rh_t),
    .hum_o   (hum)
  );

  // Delay temperature and humidity to meet the pressure result
  always_ff @(posedge clk_i) begin
    if (en) begin
      tc_dly_q[0]  <= tc;
      hum_dly_q[0] <= hum;
      for (int i = 1; i < TcDelay; i++) begin
        tc_dly_q[i] <= tc_dly_q[i-1];
      end
      for (int i = 1; i < HumDelay; i++) begin
        hum_dly_q[i] <= hum_dly_q[i-1];
      end
    end
  end

  assign out_valid_o         = vld_q[PipeDepth-1];
  assign temperature_centi_o = tc_dly_q[TcDelay-1];
  assign humidity_q22_10_o   = hum_dly_q[HumDelay-1];

endmodule

### rtl/phtc_checker.sv
// Port-level checker of the compensation block and its bind.
module phtc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [14:0] temperature_centi_o,
  input logic [31:0]        pressure_q24_8_o,
  input logic               pressure_invalid_o,
  input logic [16:0]        humidity_q22_10_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pressure_q24_8_o)
      && $stable(temperature_centi_o) && $stable(humidity_q22_10_o))
    else $error("stalled result changed");

  // Block new transactions while the output stalls
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted during output stall");

  // Invalid pressure reads as zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pressure_invalid_o |-> pressure_q24_8_o == 32'd0)
    else $error("invalid pressure not zero");

  // Temperature stays saturated
  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> temperature_centi_o >= -15'sd4000 && temperature_centi_o <= 15'sd8500)
    else $error("temperature out of range");

  // Humidity stays clamped
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> humidity_q22_10_o <= 17'd102400)
    else $error("humidity out of range");

endmodule

bind pressure_humidity_temp_compensation phtc_checker u_phtc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .temperature_centi_o (temperature_centi_o),
  .pressure_q24_8_o    (pressure_q24_8_o),
  .pressure_invalid_o  (pressure_invalid_o),
  .humidity_q22_10_o   (humidity_q22_10_o)
);

### bench/pressure_humidity_temp_compensation_test.sv
// Testbench of the pressure, humidity and temperature compensation pipeline.
`timescale 1ns / 1ps

module pressure_humidity_temp_compensation_test;
  import phtc_pkg::*;

  // Register indexes of the trim bank
  typedef enum logic [2:0] {
    RegTempTrim  = 3'd0,
    RegPressA    = 3'd1,
    RegPressB    = 3'd2,
    RegPressC    = 3'd3,
    RegHumA      = 3'd4,
    RegHumB      = 3'd5,
    RegNone6     = 3'd6,
    RegNone7     = 3'd7
  } trim_reg_e;

  localparam int NumRegs = 6;
  localparam int SettleCycles = 100;

  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
    logic [15:0] raw_h;
  } sample_t;

  typedef struct packed {
    logic signed [14:0] temp;
    logic [31:0]        press;
    logic               invalid;
    logic [16:0]        hum;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [19:0] raw_t = '0;
  logic [19:0] raw_p = '0;
  logic [15:0] raw_h = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [14:0] temp_o;
  logic [31:0] press_o;
  logic press_inv_o;
  logic [16:0] hum_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  pressure_humidity_temp_compensation i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .raw_temperature_i  (raw_t),
    .raw_pressure_i     (raw_p),
    .raw_humidity_i     (raw_h),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .temperature_centi_o(temp_o),
    .pressure_q24_8_o   (press_o),
    .pressure_invalid_o (press_inv_o),
    .humidity_q22_10_o  (hum_o),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always #5 clk = ~clk;

  logic [47:0] trim_regs [NumRegs];
  sample_t  pending_samples [$];
  reading_t expected_readings [$];
  int  errors = 0;
  int  readings_checked = 0;
  int  invalid_seen = 0;
  int  settings_used = 0;
  bit  calm = 1'b0;
  bit  hold_input = 1'b0;

  // Compensate one raw triple with the current trim bank
  function automatic reading_t compensate(sample_t s);
    logic [31:0] t1, t2, t3, d1, v1, d2, v2, tfine, tcu;
    logic signed [31:0] tc;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, num, q, e1, e2, rr;
    logic [63:0] ma, mb, qq;
    logic signed [63:0] r;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, ha, hb, hc, hd, he;
    logic signed [31:0] hs;
    logic [31:0] hum;
    reading_t res;
    t1 = {16'd0, trim_regs[0][15:0]};
    t2 = {{16{trim_regs[0][31]}}, trim_regs[0][31:16]};
    t3 = {{16{trim_regs[0][47]}}, trim_regs[0][47:32]};
    d1 = ({12'd0, s.raw_t} >> 3) - (t1 << 1);
    v1 = $signed(d1 * t2) >>> 11;
    d2 = ({12'd0, s.raw_t} >> 4) - t1;
    v2 = $signed($unsigned($signed(d2 * d2) >>> 12) * t3) >>> 14;
    tfine = v1 + v2;
    tcu = $signed(tfine * 32'd5 + 32'd128) >>> 8;
    tc = $signed(tcu);
    if (tc < -4000) tc = -4000;
    if (tc > 8500) tc = 8500;
    res.temp = tc[14:0];

    // Pressure in 64-bit wrapping arithmetic
    p1 = {48'd0, trim_regs[1][15:0]};
    p2 = {{48{trim_regs[1][31]}}, trim_regs[1][31:16]};
    p3 = {{48{trim_regs[1][47]}}, trim_regs[1][47:32]};
    p4 = {{48{trim_regs[2][15]}}, trim_regs[2][15:0]};
    p5 = {{48{trim_regs[2][31]}}, trim_regs[2][31:16]};
    p6 = {{48{trim_regs[2][47]}}, trim_regs[2][47:32]};
    p7 = {{48{trim_regs[3][15]}}, trim_regs[3][15:0]};
    p8 = {{48{trim_regs[3][31]}}, trim_regs[3][31:16]};
    p9 = {{48{trim_regs[3][47]}}, trim_regs[3][47:32]};
    a = {{32{tfine[31]}}, tfine} - 64'd128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = $unsigned($signed(a * a * p3) >>> 8) + ((a * p2) << 12);
    a = $signed(((64'd1 << 47) + a) * p1) >>> 33;
    res.invalid = (a == 64'd0);
    res.press = '0;
    if (a != 64'd0) begin
      p = 64'd1048576 - {44'd0, s.raw_p};
      num = ((p << 31) - b) * 64'd3125;
      ma = num[63] ? -num : num;
      mb = a[63] ? -a : a;
      qq = ma / mb;
      q = (num[63] != a[63]) ? -qq : qq;
      e1 = $signed(p9 * $unsigned($signed(q) >>> 13) * $unsigned($signed(q) >>> 13)) >>> 25;
      e2 = $signed(p8 * q) >>> 19;
      rr = $unsigned($signed(q + e1 + e2) >>> 8) + (p7 << 4);
      r = $signed(rr);
      if (r < 0) res.press = '0;
      else if (r > 64'sh0_FFFF_FFFF) res.press = 32'hFFFF_FFFF;
      else res.press = rr[31:0];
    end

    // Humidity in 32-bit wrapping arithmetic
    h1 = {24'd0, trim_regs[4][7:0]};
    h2 = {{16{trim_regs[4][23]}}, trim_regs[4][23:8]};
    h3 = {24'd0, trim_regs[4][31:24]};
    h4 = {{20{trim_regs[5][11]}}, trim_regs[5][11:0]};
    h5 = {{20{trim_regs[5][23]}}, trim_regs[5][23:12]};
    h6 = {{24{trim_regs[5][31]}}, trim_regs[5][31:24]};
    v = tfine - 32'd76800;
    ha = $signed(({16'd0, s.raw_h} << 14) - (h4 << 20) - h5 * v + 32'd16384) >>> 15;
    hb = $signed(v * h6) >>> 10;
    hc = $unsigned($signed(v * h3) >>> 11) + 32'd32768;
    hd = $unsigned($signed(hb * hc) >>> 10) + 32'd2097152;
    he = $signed(hd * h2 + 32'd8192) >>> 14;
    v = ha * he;
    v = v - $unsigned($signed($unsigned($signed(($signed(v) >>> 15) *
                                                ($signed(v) >>> 15)) >>> 7) * h1) >>> 4);
    hs = $signed(v);
    if (hs < 0) hum = 0;
    else if (hs > 419430400) hum = 419430400;
    else hum = v;
    res.hum = hum[28:12];
    return res;
  endfunction

  // Drive samples from the pending queue, predicting at acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_readings.push_back(compensate({raw_t, raw_p, raw_h}));
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_samples.size() > 0 && !hold_input &&
            (calm || $urandom_range(99) >= 25)) begin
          sample_t s;
          s = pending_samples.pop_front();
          in_valid <= 1'b1;
          raw_t <= s.raw_t;
          raw_p <= s.raw_p;
          raw_h <= s.raw_h;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Accept results and compare field by field
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result temp=%0d press=%0h inv=%0b hum=%0d",
                   $time, temp_o, press_o, press_inv_o, hum_o);
          errors++;
        end else begin
          reading_t e;
          e = expected_readings.pop_front();
          readings_checked++;
          if (e.invalid) invalid_seen++;
          if (temp_o !== e.temp) begin
            $display("%0t: temperature expected %0d actual %0d", $time, e.temp, temp_o);
            errors++;
          end
          if (press_o !== e.press) begin
            $display("%0t: pressure expected %0h actual %0h", $time, e.press, press_o);
            errors++;
          end
          if (press_inv_o !== e.invalid) begin
            $display("%0t: invalid expected %0b actual %0b", $time, e.invalid, press_inv_o);
            errors++;
          end
          if (hum_o !== e.hum) begin
            $display("%0t: humidity expected %0d actual %0d", $time, e.hum, hum_o);
            errors++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // Write one trim register through the configuration channel
  task automatic write_trim(trim_reg_e idx, logic [47:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NumRegs) trim_regs[idx] = (idx >= RegHumA) ? {16'd0, value[31:0]} : value;
    cfg_valid <= 1'b0;
  endtask

  task automatic load_trim_set(logic [47:0] v0, logic [47:0] v1, logic [47:0] v2,
                               logic [47:0] v3, logic [47:0] v4, logic [47:0] v5);
    write_trim(RegTempTrim, v0);
    write_trim(RegPressA, v1);
    write_trim(RegPressB, v2);
    write_trim(RegPressC, v3);
    write_trim(RegHumA, v4);
    write_trim(RegHumB, v5);
    settings_used++;
  endtask

  // Wait until the pipeline is empty and settled
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_readings.size() > 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(3))
      0: s = {20'($urandom), 20'($urandom), 16'($urandom)};
      default: s = {20'($urandom_range(400000, 600000)), 20'($urandom_range(250000, 450000)),
                    16'($urandom_range(20000, 40000))};
    endcase
    return s;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  initial begin
    for (int i = 0; i < NumRegs; i++) trim_regs[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Zero trim: divisor is zero, pressure flagged invalid
    pending_samples.push_back({20'd0, 20'd0, 16'd0});
    pending_samples.push_back({20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    drain();

    // Typical trim, directed extremes
    load_trim_set({16'hFC18, 16'd26435, 16'd27504}, {16'h0018, 16'hD5D0, 16'd36477},
                  {16'd0, 16'd140, 16'd2855}, {16'd4285, 16'hE460, 16'hFFF9},
                  {8'd0, 16'd362, 8'd75}, {8'd30, 12'd50, 12'd313});
    pending_samples.push_back({20'd519888, 20'd415148, 16'd30000});
    pending_samples.push_back({20'd0, 20'd0, 16'd0});
    pending_samples.push_back({20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    pending_samples.push_back({20'd0, 20'hFFFFF, 16'hFFFF});
    pending_samples.push_back({20'hFFFFF, 20'd0, 16'd0});
    pending_samples.push_back({20'h55555, 20'hAAAAA, 16'h5555});
    pending_samples.push_back({20'hAAAAA, 20'h55555, 16'hAAAA});
    pending_samples.push_back({20'd300000, 20'd1, 16'd65000});
    pending_samples.push_back({20'd700000, 20'd600000, 16'd1});
    drain();

    // Extreme coefficients, then unused register indexes
    load_trim_set('1, '1, '1, '1, '1, '1);
    write_trim(RegNone6, '1);
    write_trim(RegNone7, '0);
    for (int i = 0; i < 6; i++) pending_samples.push_back(random_sample());
    drain();
    load_trim_set({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'hFFFF},
                  {3{16'h8000}}, {3{16'h7FFF}}, {8'hFF, 16'h7FFF, 8'hFF},
                  {8'h80, 12'h800, 12'h7FF});
    for (int i = 0; i < 6; i++) pending_samples.push_back(random_sample());
    drain();

    // Random phases: typical-ish trims with random perturbation, alternating with fully random trims
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0)
        load_trim_set({16'($urandom_range(0, 2000)) - 16'd1000, 16'($urandom_range(20000, 30000)),
                       16'($urandom_range(26000, 30000))},
                      {16'($urandom_range(0, 2000)) - 16'd1000 + 16'hD5D0,
                       16'($urandom_range(30000, 40000))},
                      {16'($urandom_range(0, 20)), 16'($urandom_range(0, 300)),
                       16'($urandom_range(2000, 9000))},
                      {16'($urandom_range(3000, 5000)), 16'hE460, 16'hFFF9},
                      {8'($urandom), 16'($urandom_range(300, 400)), 8'($urandom)},
                      {8'($urandom_range(20, 40)), 12'($urandom_range(0, 100)),
                       12'($urandom_range(250, 400))});
      else
        load_trim_set(rand48(), rand48(), rand48(), rand48(), rand48(), rand48());
      calm = (ph == 2);
      for (int i = 0; i < 290; i++) pending_samples.push_back(random_sample());
      if (ph == 4) begin
        // Hold input until every outstanding result has drained
        while (pending_samples.size() > 150) @(posedge clk);
        hold_input = 1'b1;
        while (in_valid || expected_readings.size() > 0) @(posedge clk);
        hold_input = 1'b0;
      end
      drain();
      calm = 1'b0;
    end

    $display("Covered %0d compensated readings over %0d trim settings, %0d flagged invalid.",
             readings_checked, settings_used, invalid_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
